// ===== hdl/lcdis_pkg.sv =====
// Shared constants, command tables and result type for the LCD init command sequencer.
package lcdis_pkg;

  localparam int INIT_STEPS      = 21;
  localparam int INIT_DATA_BYTES = 54;
  localparam int TABLE_LEN       = 20;

  // Number of table entries walked during init.
  localparam logic [4:0] STEP_LIMIT = 5'((INIT_STEPS < TABLE_LEN) ? INIT_STEPS : TABLE_LEN);
  localparam logic [6:0] DATA_LIMIT = 7'(INIT_DATA_BYTES);

  // Input command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_INIT   = 2'd1;
  localparam logic [1:0] CMD_WINDOW = 2'd2;
  localparam logic [1:0] CMD_SLEEP  = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_RST_LO  = 3'd2;
  localparam logic [2:0] KIND_RST_HI  = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  // Panel opcodes
  localparam logic [7:0] OP_COLUMN_ADDR = 8'h2a;
  localparam logic [7:0] OP_ROW_ADDR    = 8'h2b;
  localparam logic [7:0] OP_MEM_WRITE   = 8'h2c;
  localparam logic [7:0] OP_DISPLAY_OFF = 8'h28;
  localparam logic [7:0] OP_SLEEP_IN    = 8'h10;

  // Waits in ms
  localparam logic [6:0] WAIT_LONG  = 7'h78;
  localparam logic [6:0] WAIT_SHORT = 7'h32;
  localparam logic [6:0] WAIT_PULSE = 7'd20;

  // Config register indexes
  localparam logic REG_TICKS_PER_MS = 1'b0;

  localparam logic [7:0] OP_CODE [32] = '{
    8'h11, 8'h36, 8'h3A, 8'hB0, 8'hB2, 8'hB7, 8'hBB, 8'hC0, 8'hC2, 8'hC3,
    8'hC4, 8'hC6, 8'hD0, 8'hE0, 8'hE1, 8'h21, 8'h2A, 8'h2B, 8'h29, 8'h2C,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00};

  localparam logic [3:0] OP_LEN [32] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd2, 4'd14, 4'd14, 4'd0, 4'd4, 4'd4, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0};

  localparam logic [6:0] OP_WAIT [32] = '{
    WAIT_LONG, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, WAIT_SHORT, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0};

  localparam logic [7:0] OP_DATA [64] = '{
    8'h00, 8'h05, 8'h00, 8'hF8, 8'h0C, 8'h0C, 8'h00, 8'h33, 8'h33, 8'h35,
    8'h19, 8'h2C, 8'h01, 8'h12, 8'h20, 8'h0F, 8'hA4, 8'hA1,
    8'h00, 8'h19, 8'h1e, 8'h0a, 8'h09, 8'h15, 8'h3d, 8'h44, 8'h51, 8'h12,
    8'h03, 8'h00, 8'h3f, 8'h3f,
    8'h00, 8'h18, 8'h1e, 8'h0a, 8'h09, 8'h25, 8'h3f, 8'h43, 8'h52, 8'h33,
    8'h03, 8'h00, 8'h3f, 8'h3f,
    8'h00, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00, 8'h01, 8'h3F,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       last;
  } res_t;

endpackage

// ===== hdl/lcdis_if.sv =====
// Request and result channel interfaces for the LCD init command sequencer.
interface lcdis_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] x_end;
  logic [15:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lcdis_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, kind, byte_value, last, input ready);
  modport sink (input valid, kind, byte_value, last, output ready);
endinterface

// ===== hdl/lcdis_core.sv =====
// Sequencer state and per-item next-state / result logic.
module lcdis_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [1:0]          command_i,
  input  logic [15:0]         x_start_i,
  input  logic [15:0]         y_start_i,
  input  logic [15:0]         x_end_i,
  input  logic [15:0]         y_end_i,
  input  logic [15:0]         ticks_per_ms_i,
  output lcdis_pkg::res_t     res_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RESET  = 3'd1,
    PH_TABLE  = 3'd2,
    PH_WINDOW = 3'd3,
    PH_SLEEP  = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  step_q, step_d;
  logic [5:0]  dptr_q, dptr_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [6:0]  wait_q, wait_d;
  logic [15:0] presc_q, presc_d;
  logic [15:0] xs_q, ys_q, xe_q, ye_q;

  logic [4:0]  step_inc;
  logic [3:0]  bl_dec;
  logic [6:0]  wait_dec;
  logic [16:0] presc_inc;
  logic [6:0]  entry_wait;
  logic        entry_done;
  lcdis_pkg::res_t res;

  assign step_inc   = step_q + 5'd1;
  assign bl_dec     = bytes_left_q - 4'd1;
  assign wait_dec   = wait_q - 7'd1;
  assign presc_inc  = {1'b0, presc_q} + 17'd1;
  assign entry_wait = lcdis_pkg::OP_WAIT[step_q];
  assign entry_done = (step_inc >= lcdis_pkg::STEP_LIMIT);

  always_comb begin
    phase_d      = phase_q;
    step_d       = step_q;
    dptr_d       = dptr_q;
    bytes_left_d = bytes_left_q;
    wait_d       = wait_q;
    presc_d      = presc_q;
    res          = '0;
    if (en_i) begin
      if (command_i != lcdis_pkg::CMD_TICK) begin
        if (phase_q != PH_IDLE) begin
          // busy: report and drop the request
          res.valid = 1'b1;
          res.kind  = lcdis_pkg::KIND_IGNORED;
        end else begin
          step_d       = '0;
          dptr_d       = '0;
          bytes_left_d = '0;
          wait_d       = '0;
          presc_d      = '0;
          case (command_i)
            lcdis_pkg::CMD_INIT:   phase_d = PH_RESET;
            lcdis_pkg::CMD_WINDOW: phase_d = PH_WINDOW;
            default:               phase_d = PH_SLEEP;
          endcase
        end
      end else if (phase_q == PH_IDLE) begin
        // nothing to do
      end else if (wait_q != '0) begin
        // spend one tick of the wait
        if (presc_inc >= {1'b0, ticks_per_ms_i}) begin
          presc_d = '0;
          wait_d  = wait_dec;
          if (wait_dec == '0 &&
              ((phase_q == PH_TABLE && step_q >= lcdis_pkg::STEP_LIMIT) ||
               (phase_q == PH_SLEEP && step_q >= 5'd2))) begin
            phase_d = PH_IDLE;
          end
        end else begin
          presc_d = presc_inc[15:0];
        end
      end else begin
        unique case (phase_q)
          PH_RESET: begin
            res.valid = 1'b1;
            if (step_q < 5'd2) begin
              wait_d   = lcdis_pkg::WAIT_PULSE;
              presc_d  = '0;
              step_d   = step_inc;
              res.kind = (step_q == 5'd1) ? lcdis_pkg::KIND_RST_LO : lcdis_pkg::KIND_RST_HI;
            end else begin
              wait_d       = lcdis_pkg::WAIT_LONG;
              presc_d      = '0;
              phase_d      = PH_TABLE;
              step_d       = '0;
              dptr_d       = '0;
              bytes_left_d = '0;
              res.kind     = lcdis_pkg::KIND_RST_HI;
            end
          end
          PH_TABLE: begin
            if (step_q >= lcdis_pkg::STEP_LIMIT) begin
              phase_d = PH_IDLE;
            end else begin
              res.valid = 1'b1;
              if (bytes_left_q == '0) begin
                res.kind       = lcdis_pkg::KIND_CMD;
                res.byte_value = lcdis_pkg::OP_CODE[step_q];
                bytes_left_d   = lcdis_pkg::OP_LEN[step_q];
              end else begin
                res.kind       = lcdis_pkg::KIND_DATA;
                res.byte_value = ({1'b0, dptr_q} < lcdis_pkg::DATA_LIMIT) ?
                                 lcdis_pkg::OP_DATA[dptr_q] : 8'h00;
                if (dptr_q != 6'h3f) begin
                  dptr_d = dptr_q + 6'd1;
                end
                bytes_left_d = bl_dec;
              end
              // close the entry once its last byte goes out
              if (bytes_left_d == '0) begin
                wait_d   = entry_wait;
                presc_d  = '0;
                step_d   = step_inc;
                res.last = entry_done;
                if (entry_wait == '0 && entry_done) begin
                  phase_d = PH_IDLE;
                end
              end
            end
          end
          PH_WINDOW: begin
            res.valid = 1'b1;
            res.kind  = lcdis_pkg::KIND_DATA;
            step_d    = step_inc;
            case (step_q)
              5'd0: begin
                res.kind       = lcdis_pkg::KIND_CMD;
                res.byte_value = lcdis_pkg::OP_COLUMN_ADDR;
              end
              5'd1: res.byte_value = xs_q[15:8];
              5'd2: res.byte_value = xs_q[7:0];
              5'd3: res.byte_value = xe_q[15:8];
              5'd4: res.byte_value = xe_q[7:0];
              5'd5: begin
                res.kind       = lcdis_pkg::KIND_CMD;
                res.byte_value = lcdis_pkg::OP_ROW_ADDR;
              end
              5'd6: res.byte_value = ys_q[15:8];
              5'd7: res.byte_value = ys_q[7:0];
              5'd8: res.byte_value = ye_q[15:8];
              5'd9: res.byte_value = ye_q[7:0];
              default: begin
                phase_d        = PH_IDLE;
                res.kind       = lcdis_pkg::KIND_CMD;
                res.byte_value = lcdis_pkg::OP_MEM_WRITE;
                res.last       = 1'b1;
              end
            endcase
          end
          PH_SLEEP: begin
            res.valid = 1'b1;
            res.kind  = lcdis_pkg::KIND_CMD;
            presc_d   = '0;
            if (step_q == '0) begin
              step_d         = 5'd1;
              wait_d         = lcdis_pkg::WAIT_SHORT;
              res.byte_value = lcdis_pkg::OP_DISPLAY_OFF;
            end else begin
              step_d         = 5'd2;
              wait_d         = lcdis_pkg::WAIT_LONG;
              res.byte_value = lcdis_pkg::OP_SLEEP_IN;
              res.last       = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      step_q       <= '0;
      dptr_q       <= '0;
      bytes_left_q <= '0;
      wait_q       <= '0;
      presc_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      step_q       <= step_d;
      dptr_q       <= dptr_d;
      bytes_left_q <= bytes_left_d;
      wait_q       <= wait_d;
      presc_q      <= presc_d;
    end
  end

  // Latch window corners on an accepted set-window request while idle.
  always_ff @(posedge clk_i) begin
    if (en_i && command_i == lcdis_pkg::CMD_WINDOW && phase_q == PH_IDLE) begin
      xs_q <= x_start_i;
      ys_q <= y_start_i;
      xe_q <= x_end_i;
      ye_q <= y_end_i;
    end
  end

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q != '0 |-> phase_q != PH_IDLE)
    else $error("wait pending while idle");

  a_bytes_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q != '0 |-> phase_q == PH_TABLE)
    else $error("data bytes pending outside init table");

  a_window_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WINDOW |-> step_q <= 5'd10)
    else $error("window step out of range");

  a_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.kind == lcdis_pkg::KIND_IGNORED) |=> $stable(phase_q))
    else $error("dropped request changed phase");

endmodule

// ===== hdl/lcd_init_command_sequencer_top.sv =====
// Top level of the LCD init command sequencer: channels, config register, result register.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  req_i   | in  | valid/ready      | command, x_start, y_start, x_end, y_end
//  res_o   | out | valid/ready      | kind, byte_value, last
//  apb     | in  | psel/penable     | paddr, pwdata -> ticks_per_ms, prdata
//
// One item per cycle while the output register is free or draining: each accepted
// item is fully handled in the cycle it is accepted, and its result (if any) lands in
// the output register at that edge, so it is valid in the cycle after the accept.
// rst_ni clears the sequencer to idle and ticks_per_ms to 1000.
// A held result stalls intake only when res_o.ready is low; a result being
// taken in the same cycle frees the register for the next item.
module lcd_init_command_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcdis_req_if.sink         req_i,
  lcdis_res_if.source       res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0]     tpm_q, tpm_d;
  logic            res_valid_q, res_valid_d;
  logic [2:0]      kind_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            accept;
  logic            cfg_wr;
  lcdis_pkg::res_t core_res;

  // Take a new item whenever the output register is empty or draining.
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Config port: single register, pready held high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lcdis_pkg::REG_TICKS_PER_MS);
  assign prdata = (paddr[2] == lcdis_pkg::REG_TICKS_PER_MS) ? {16'h0000, tpm_q} : 32'h0;

  always_comb begin
    tpm_d = tpm_q;
    if (cfg_wr) begin
      tpm_d = pwdata[15:0];
    end
  end

  lcdis_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (accept),
    .command_i      (req_i.command),
    .x_start_i      (req_i.x_start),
    .y_start_i      (req_i.y_start),
    .x_end_i        (req_i.x_end),
    .y_end_i        (req_i.y_end),
    .ticks_per_ms_i (tpm_q),
    .res_o          (core_res)
  );

  // Load on a fresh result, drop once the sink takes it.
  always_comb begin
    res_valid_d = res_valid_q;
    if (core_res.valid) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q       <= 16'd1000;
      res_valid_q <= 1'b0;
    end else begin
      tpm_q       <= tpm_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res.valid) begin
      kind_q <= core_res.kind;
      byte_q <= core_res.byte_value;
      last_q <= core_res.last;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.byte_value = byte_q;
  assign res_o.last       = last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !core_res.valid)
    else $error("result produced while output register held");

  a_result_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid |-> accept)
    else $error("result produced without an accepted item");

  a_cfg_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_wr) |-> $stable(tpm_q) || $past(!rst_ni))
    else $error("ticks_per_ms changed without a write");

endmodule

// ===== bench/tb_lcd_init_command_sequencer_top.sv =====
// Self-checking bench for the LCD init command sequencer: byte-stream scoreboard, drivers, monitor.
module tb_lcd_init_command_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The init table as the panel expects it: opcode, argument count and
  // trailing pause of each entry, then the argument bytes in walk order.
  localparam int WALKED_STEPS = (lcdis_pkg::INIT_STEPS < 20) ? lcdis_pkg::INIT_STEPS : 20;

  localparam logic [7:0] INIT_OPCODE [20] = '{
    8'h11, 8'h36, 8'h3A, 8'hB0, 8'hB2, 8'hB7, 8'hBB, 8'hC0, 8'hC2, 8'hC3,
    8'hC4, 8'hC6, 8'hD0, 8'hE0, 8'hE1, 8'h21, 8'h2A, 8'h2B, 8'h29, 8'h2C};

  localparam logic [3:0] INIT_ARG_COUNT [20] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd2, 4'd14, 4'd14, 4'd0, 4'd4, 4'd4, 4'd0, 4'd0};

  // Sleep-out (first entry) and display-on (entry 18) are followed by pauses.
  localparam logic [6:0] INIT_PAUSE_MS [20] = '{
    lcdis_pkg::WAIT_LONG, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, lcdis_pkg::WAIT_SHORT, 7'd0};

  localparam logic [7:0] INIT_ARGS [64] = '{
    8'h00, 8'h05, 8'h00, 8'hF8, 8'h0C, 8'h0C, 8'h00, 8'h33, 8'h33, 8'h35,
    8'h19, 8'h2C, 8'h01, 8'h12, 8'h20, 8'h0F, 8'hA4, 8'hA1,
    8'h00, 8'h19, 8'h1E, 8'h0A, 8'h09, 8'h15, 8'h3D, 8'h44, 8'h51, 8'h12,
    8'h03, 8'h00, 8'h3F, 8'h3F,
    8'h00, 8'h18, 8'h1E, 8'h0A, 8'h09, 8'h25, 8'h3F, 8'h43, 8'h52, 8'h33,
    8'h03, 8'h00, 8'h3F, 8'h3F,
    8'h00, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00, 8'h01, 8'h3F,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  // ticks_per_ms lives at byte address 0.
  localparam logic [2:0] TICK_RATE_ADDR = {lcdis_pkg::REG_TICKS_PER_MS, 2'b00};

  // Tick rates of the random phases. 65535 makes any pause far too long to
  // wait out, so that phase runs set-window sequences only.
  localparam logic [15:0] RANDOM_RATES [2] = '{16'd1, 16'hFFFF};
  localparam int PHASE_ITEMS = 120;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_RESET_PULSE, SEQ_INIT_TABLE, SEQ_WINDOW, SEQ_SLEEP
  } seq_phase_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       last;
  } panel_item_t;

  // Tracks the sequencer state, predicts the panel item each accepted request
  // causes and checks the items the block hands out in order.
  class panel_stream_scoreboard;
    panel_item_t awaited_items[$];
    seq_phase_e  phase;
    logic [4:0]  step;
    logic [5:0]  arg_ptr;
    logic [3:0]  args_left;
    logic [6:0]  pause_ms;
    logic [15:0] prescale;
    logic [15:0] window_corner [4];
    logic [15:0] ticks_per_ms;
    int errors, checked, requests, inits, windows, sleeps, rejected;

    function new();
      ticks_per_ms = 16'd1000;
      phase = SEQ_IDLE;
      step = '0;
      arg_ptr = '0;
      args_left = '0;
      pause_ms = '0;
      prescale = '0;
      foreach (window_corner[i]) window_corner[i] = '0;
    endfunction

    function void set_ticks_per_ms(logic [15:0] rate);
      ticks_per_ms = rate;
    endfunction

    function bit busy();
      return phase != SEQ_IDLE;
    endfunction

    function int pending();
      return awaited_items.size();
    endfunction

    function void await_item(logic [2:0] kind, logic [7:0] value, logic last);
      panel_item_t item;
      item.kind = kind;
      item.byte_value = value;
      item.last = last;
      awaited_items.push_back(item);
    endfunction

    function void arm_pause(logic [6:0] ms);
      pause_ms = ms;
      prescale = '0;
    endfunction

    // Drop to idle once the final entry is out and its pause is over.
    function void retire_if_done();
      if (pause_ms != 0) return;
      if ((phase == SEQ_INIT_TABLE && step >= WALKED_STEPS) ||
          (phase == SEQ_SLEEP && step >= 2))
        phase = SEQ_IDLE;
    endfunction

    // Close the current table entry; flag it when it was the final one.
    function logic close_entry();
      arm_pause(INIT_PAUSE_MS[step]);
      step = step + 5'd1;
      retire_if_done();
      return step >= WALKED_STEPS;
    endfunction

    function void note_request(logic [1:0] cmd, logic [15:0] xs, logic [15:0] ys,
                               logic [15:0] xe, logic [15:0] ye);
      logic [7:0] arg;
      logic       fin;
      logic [4:0] s;
      if (cmd != lcdis_pkg::CMD_TICK) begin
        requests++;
        if (phase != SEQ_IDLE) begin
          rejected++;
          await_item(lcdis_pkg::KIND_IGNORED, 8'h00, 1'b0);
          return;
        end
        step = '0;
        arg_ptr = '0;
        args_left = '0;
        arm_pause('0);
        case (cmd)
          lcdis_pkg::CMD_INIT: begin
            phase = SEQ_RESET_PULSE;
            inits++;
          end
          lcdis_pkg::CMD_WINDOW: begin
            window_corner[0] = xs;
            window_corner[1] = ys;
            window_corner[2] = xe;
            window_corner[3] = ye;
            phase = SEQ_WINDOW;
            windows++;
          end
          default: begin
            phase = SEQ_SLEEP;
            sleeps++;
          end
        endcase
        return;
      end
      if (phase == SEQ_IDLE) return;
      requests++;
      if (pause_ms != 0) begin
        // A rate of zero behaves as one tick per millisecond.
        if ({1'b0, prescale} + 17'd1 >= {1'b0, ticks_per_ms}) begin
          prescale = '0;
          pause_ms = pause_ms - 7'd1;
          retire_if_done();
        end else begin
          prescale = prescale + 16'd1;
        end
        return;
      end
      s = step;
      case (phase)
        SEQ_RESET_PULSE: begin
          if (s < 2) begin
            arm_pause(lcdis_pkg::WAIT_PULSE);
            step = s + 5'd1;
            await_item((s == 1) ? lcdis_pkg::KIND_RST_LO : lcdis_pkg::KIND_RST_HI,
                       8'h00, 1'b0);
          end else begin
            arm_pause(lcdis_pkg::WAIT_LONG);
            phase = SEQ_INIT_TABLE;
            step = '0;
            arg_ptr = '0;
            args_left = '0;
            await_item(lcdis_pkg::KIND_RST_HI, 8'h00, 1'b0);
          end
        end
        SEQ_INIT_TABLE: begin
          if (s >= WALKED_STEPS) begin
            phase = SEQ_IDLE;
          end else if (args_left == 0) begin
            args_left = INIT_ARG_COUNT[s];
            fin = (args_left == 0) ? close_entry() : 1'b0;
            await_item(lcdis_pkg::KIND_CMD, INIT_OPCODE[s], fin);
          end else begin
            arg = (arg_ptr < lcdis_pkg::INIT_DATA_BYTES) ? INIT_ARGS[arg_ptr] : 8'h00;
            if (arg_ptr < 6'd63) arg_ptr = arg_ptr + 6'd1;
            args_left = args_left - 4'd1;
            fin = (args_left == 0) ? close_entry() : 1'b0;
            await_item(lcdis_pkg::KIND_DATA, arg, fin);
          end
        end
        SEQ_WINDOW: begin
          step = s + 5'd1;
          case (s)
            0: await_item(lcdis_pkg::KIND_CMD, lcdis_pkg::OP_COLUMN_ADDR, 1'b0);
            1: await_item(lcdis_pkg::KIND_DATA, window_corner[0][15:8], 1'b0);
            2: await_item(lcdis_pkg::KIND_DATA, window_corner[0][7:0], 1'b0);
            3: await_item(lcdis_pkg::KIND_DATA, window_corner[2][15:8], 1'b0);
            4: await_item(lcdis_pkg::KIND_DATA, window_corner[2][7:0], 1'b0);
            5: await_item(lcdis_pkg::KIND_CMD, lcdis_pkg::OP_ROW_ADDR, 1'b0);
            6: await_item(lcdis_pkg::KIND_DATA, window_corner[1][15:8], 1'b0);
            7: await_item(lcdis_pkg::KIND_DATA, window_corner[1][7:0], 1'b0);
            8: await_item(lcdis_pkg::KIND_DATA, window_corner[3][15:8], 1'b0);
            9: await_item(lcdis_pkg::KIND_DATA, window_corner[3][7:0], 1'b0);
            default: begin
              phase = SEQ_IDLE;
              await_item(lcdis_pkg::KIND_CMD, lcdis_pkg::OP_MEM_WRITE, 1'b1);
            end
          endcase
        end
        SEQ_SLEEP: begin
          if (s == 0) begin
            step = 5'd1;
            arm_pause(lcdis_pkg::WAIT_SHORT);
            await_item(lcdis_pkg::KIND_CMD, lcdis_pkg::OP_DISPLAY_OFF, 1'b0);
          end else begin
            step = 5'd2;
            arm_pause(lcdis_pkg::WAIT_LONG);
            await_item(lcdis_pkg::KIND_CMD, lcdis_pkg::OP_SLEEP_IN, 1'b1);
          end
        end
        default: phase = SEQ_IDLE;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] value, logic last);
      panel_item_t want;
      checked++;
      if (awaited_items.size() == 0) begin
        errors++;
        $error("unexpected item: kind %0d byte_value 0x%0h last %0d", kind, value, last);
        return;
      end
      want = awaited_items.pop_front();
      compare_field("kind", 8'(want.kind), 8'(kind));
      compare_field("byte_value", want.byte_value, value);
      compare_field("last", 8'(want.last), 8'(last));
    endfunction

    function void report_leftover();
      if (awaited_items.size() != 0) begin
        errors += awaited_items.size();
        $error("%0d expected items never arrived", awaited_items.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Set for a whole sequence now and then: no gaps on either side.
  bit steady;

  lcdis_req_if req_bus ();
  lcdis_res_if res_bus ();

  panel_stream_scoreboard sb = new();

  lcd_init_command_sequencer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 96) return $urandom_range(5, 9);
    return $urandom_range(12, 24);
  endfunction

  function automatic int sender_gap();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    return idle_length();
  endfunction

  // Bias window corners toward the all-zero and all-one extremes.
  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] any_request();
    case ($urandom_range(0, 2))
      0: return lcdis_pkg::CMD_INIT;
      1: return lcdis_pkg::CMD_WINDOW;
      default: return lcdis_pkg::CMD_SLEEP;
    endcase
  endfunction

  // Sample results at the rising edge; the scoreboard pops the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready)
      sb.check_result(res_bus.kind, res_bus.byte_value, res_bus.last);
  end

  // Result sink: drop ready for random stretches unless a steady run is on.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = idle_length();
      end
    end
  end

  // Present one item after a random gap, hold it until accepted, then note it.
  task automatic send_item(logic [1:0] cmd, logic [15:0] xs, logic [15:0] ys,
                           logic [15:0] xe, logic [15:0] ye);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_bus.valid   <= 1'b1;
    req_bus.command <= cmd;
    req_bus.x_start <= xs;
    req_bus.y_start <= ys;
    req_bus.x_end   <= xe;
    req_bus.y_end   <= ye;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    sb.note_request(cmd, xs, ys, xe, ye);
  endtask

  // Tick slots carry random corner fields; the block must ignore them.
  task automatic send_tick();
    send_item(lcdis_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic send_request(logic [1:0] cmd);
    send_item(cmd, corner_value(), corner_value(), corner_value(), corner_value());
  endtask

  // Tick the running sequence to its end, pauses included.
  task automatic finish_sequence();
    while (sb.busy()) send_tick();
  endtask

  // Hold off the sender until every expected item is out.
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic verify_tick_rate();
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TICK_RATE_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {16'h0000, sb.ticks_per_ms}) begin
      sb.errors++;
      $error("ticks_per_ms: expected %0d, got %0d", sb.ticks_per_ms, got);
    end
  endtask

  // Write the tick rate with the sequencer idle and the result path empty,
  // then read it back.
  task automatic write_tick_rate(logic [15:0] rate);
    finish_sequence();
    drain();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TICK_RATE_ADDR;
    pwdata  <= {16'h0000, rate};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_ticks_per_ms(rate);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    verify_tick_rate();
  endtask

  // One random episode: mostly a well-formed sequence ticked to its end with
  // rejected requests sprinkled in; sometimes idle ticks or a full drain.
  task automatic random_episode(bit windows_only);
    int pick;
    logic [1:0] cmd;
    steady = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) send_tick();
      return;
    end
    if (pick < 10) begin
      drain();
      return;
    end
    if (windows_only || (pick >= 30 && pick < 80)) cmd = lcdis_pkg::CMD_WINDOW;
    else if (pick < 30) cmd = lcdis_pkg::CMD_INIT;
    else cmd = lcdis_pkg::CMD_SLEEP;
    send_request(cmd);
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < 6) send_request(any_request());
      else send_tick();
    end
  endtask

  initial begin : stimulus
    int target;
    int guard;
    rst_ni          = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.command = lcdis_pkg::CMD_TICK;
    req_bus.x_start = '0;
    req_bus.y_start = '0;
    req_bus.x_end   = '0;
    req_bus.y_end   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    steady          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset rate: the reset value reads back, a tick
    // while idle, and set-window at the corner extremes with every request
    // type rejected while the window is in flight.
    verify_tick_rate();
    send_tick();
    send_item(lcdis_pkg::CMD_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(lcdis_pkg::CMD_INIT);
    send_tick();
    send_request(lcdis_pkg::CMD_SLEEP);
    send_tick();
    send_request(lcdis_pkg::CMD_WINDOW);
    finish_sequence();
    send_item(lcdis_pkg::CMD_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    finish_sequence();
    send_item(lcdis_pkg::CMD_WINDOW, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    finish_sequence();
    drain();

    // Lowest nonzero tick rate: full init with a rejected request inside the reset
    // pulse pause (it must not count as a tick), then sleep.
    write_tick_rate(16'd1);
    send_request(lcdis_pkg::CMD_INIT);
    repeat (3) send_tick();
    send_request(lcdis_pkg::CMD_WINDOW);
    finish_sequence();
    send_tick();
    send_request(lcdis_pkg::CMD_SLEEP);
    repeat (10) send_tick();
    send_request(lcdis_pkg::CMD_INIT);
    finish_sequence();

    // A rate of zero must behave as one tick per millisecond.
    write_tick_rate(16'd0);
    send_request(lcdis_pkg::CMD_SLEEP);
    finish_sequence();

    // Random part, one phase per tick rate.
    foreach (RANDOM_RATES[i]) begin
      write_tick_rate(RANDOM_RATES[i]);
      target = sb.requests + PHASE_ITEMS;
      while (sb.requests < target) random_episode(RANDOM_RATES[i] == 16'hFFFF);
    end

    // Stop sending and let the last items come out.
    steady = 1'b0;
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    sb.report_leftover();

    $display("Sent %0d requests and busy ticks: %0d init, %0d window, %0d sleep, %0d rejected",
             sb.requests, sb.inits, sb.windows, sb.sleeps, sb.rejected);
    $display("Checked %0d panel items over tick rates 1000, 1, 0 and 65535",
             sb.checked);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== lcd_init_command_sequencer_top.f =====
hdl/lcdis_pkg.sv
hdl/lcdis_if.sv
hdl/lcdis_core.sv
hdl/lcd_init_command_sequencer_top.sv
bench/tb_lcd_init_command_sequencer_top.sv
